[design/phr_pkg.sv]
// Shared widths, fixed-point constants and the byte-to-fraction table for the HSL to RGB unit.
`default_nettype none

package phr_pkg;

  // Fixed-point format: unsigned fractions with FB fraction bits.
  localparam int FB   = 16;
  localparam int FXW  = FB + 1;          // holds 0 .. ONE inclusive
  localparam int PRW  = 2 * FXW;         // product of two fractions
  localparam int H6W  = FB + 3;          // six times a hue below one
  localparam int DBW  = FXW + 1;         // doubled channel, 0 .. 2*ONE
  localparam int SCW  = FXW + 3;         // signed doubled channel before clamping
  localparam int BYW  = 8;
  localparam int PCW  = 3 * BYW;
  localparam int FLW  = 8;
  localparam int NSTG = 8;

  localparam logic [FLW-1:0] FLOOR_RESET = FLW'(128);

  localparam logic [FXW-1:0] ONE_FX  = FXW'(1) << FB;
  localparam logic [PRW-1:0] HALF_PR = PRW'(1) << (FB - 1);
  localparam logic [DBW-1:0] TWO_FX  = DBW'(1) << (FB + 1);

  typedef logic [FXW-1:0] fx_t;
  typedef logic [FXW-1:0] fx_lut_t [256];

  // byte/255 as a fraction, rounded to nearest, worked out at elaboration.
  function automatic fx_lut_t build_byte_lut();
    fx_lut_t lut;
    longint  tmp;
    for (int i = 0; i < 256; i++) begin
      tmp    = (longint'(i) * (longint'(2) << FB) + 255) / 510;
      lut[i] = tmp[FXW-1:0];
    end
    return lut;
  endfunction

  localparam fx_lut_t BYTE_TO_FX = build_byte_lut();

  // Product of two fractions rescaled to one fraction, rounded half up.
  function automatic fx_t mul_round(input logic [PRW-1:0] prod);
    logic [PRW-1:0] sum;
    sum = prod + HALF_PR;
    return sum[FB +: FXW];
  endfunction

endpackage

`default_nettype wire

[design/phr_if.sv]
// Channel interfaces of the HSL to RGB unit: colour input, RGB result and floor register write.
`default_nettype none

interface phr_in_if import phr_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [PCW-1:0] packed_color;

  modport source (output valid, output packed_color, input ready);
  modport sink   (input valid, input packed_color, output ready);
endinterface

interface phr_out_if import phr_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [BYW-1:0] red;
  logic [BYW-1:0] green;
  logic [BYW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface phr_cfg_if import phr_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [FLW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/packed_hsl_to_rgb_unit.sv]
// Pipelined packed HSL to RGB colour converter.
//
//   Channel    Direction  Payload                        Transfer when
//   in_chan    sink       packed_color[23:0]             valid && ready
//   out_chan   source     red, green, blue [7:0]         valid && ready
//   cfg_chan   sink       data[7:0] (lightness floor)    valid && ready (ready is always high)
//
// Eight register stages. One colour is taken per cycle while the output is not held back,
// because every stage can then load on every cycle. Its result passes through the stages in
// order and is presented from the last stage until it is taken.
// The depth is set by the chain of three multipliers (lightness remap, chroma, secondary
// component), each followed by its own rounding stage.
// Each stage moves on when it is empty or the stage after it moves, so bubbles
// close up under a stall and nothing is lost or repeated.
// Reset clears the valid bits and sets the lightness floor to one half.
`default_nettype none

module packed_hsl_to_rgb_unit import phr_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  phr_in_if.sink      in_chan,
  phr_out_if.source   out_chan,
  phr_cfg_if.sink     cfg_chan
);

  logic [FLW-1:0]  floor_r;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  // Stage registers.
  logic [FB-1:0]  h1_r;
  fx_t            s1_r, ls1_r;
  logic [PRW-1:0] pl2_r;
  logic [H6W-1:0] h62_r;
  fx_t            s2_r;
  logic [DBW-1:0] l23_r, l24_r, l25_r, l26_r;
  fx_t            span3_r, s3_r, omd3_r, omd4_r, omd5_r;
  logic [2:0]     sec3_r, sec4_r, sec5_r, sec6_r;
  logic [PRW-1:0] pc4_r, px6_r;
  fx_t            c5_r, c6_r;
  logic [DBW-1:0] rd7_r, gd7_r, bd7_r;
  logic [BYW-1:0] red_r, green_r, blue_r;

  // Next values.
  logic [FB-1:0]  h1_nxt;
  fx_t            s1_nxt, ls1_nxt;
  logic [PRW-1:0] pl2_nxt;
  logic [H6W-1:0] h62_nxt;
  logic [DBW-1:0] l23_nxt;
  fx_t            span3_nxt, omd3_nxt;
  logic [2:0]     sec3_nxt;
  logic [PRW-1:0] pc4_nxt, px6_nxt;
  fx_t            c5_nxt;
  logic [DBW-1:0] rd7_nxt, gd7_nxt, bd7_nxt;
  logic [BYW-1:0] red_nxt, green_nxt, blue_nxt;

  logic [FB-1:0]  flo;
  fx_t            omf;

  // The floor register takes every write at once.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= FLOOR_RESET;
    end else if (cfg_chan.valid) begin
      floor_r <= cfg_chan.data;
    end
  end

  assign flo = {floor_r, (FB - FLW)'(0)};
  assign omf = ONE_FX - FXW'(flo);

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_chan.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 1: bytes to fractions; a hue of exactly one wraps to zero.
  always_comb begin
    fx_t hfx;
    hfx     = BYTE_TO_FX[in_chan.packed_color[23:16]];
    h1_nxt  = hfx[FB-1:0];
    s1_nxt  = BYTE_TO_FX[in_chan.packed_color[15:8]];
    ls1_nxt = BYTE_TO_FX[in_chan.packed_color[7:0]];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1_r  <= h1_nxt;
      s1_r  <= s1_nxt;
      ls1_r <= ls1_nxt;
    end
  end

  // Stage 2: lightness remap product and six times the hue.
  assign pl2_nxt = PRW'(ls1_r) * PRW'(omf);
  assign h62_nxt = H6W'(h1_r) * H6W'(6);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pl2_r <= pl2_nxt;
      h62_r <= h62_nxt;
      s2_r  <= s1_r;
    end
  end

  // Stage 3: lightness, chroma span and hue distance from the centre of its sector pair.
  always_comb begin
    fx_t            l;
    logic [DBW-1:0] ldev;
    fx_t            t;
    fx_t            d;
    l        = FXW'(flo) + mul_round(pl2_r);
    l23_nxt  = {l, 1'b0};
    ldev     = (l23_nxt >= DBW'(ONE_FX)) ? l23_nxt - DBW'(ONE_FX) : DBW'(ONE_FX) - l23_nxt;
    span3_nxt = (ldev >= DBW'(ONE_FX)) ? '0 : ONE_FX - ldev[FXW-1:0];
    t        = h62_r[FXW-1:0];
    d        = (t >= ONE_FX) ? t - ONE_FX : ONE_FX - t;
    omd3_nxt = ONE_FX - d;
    sec3_nxt = h62_r[H6W-1:FB];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      l23_r   <= l23_nxt;
      span3_r <= span3_nxt;
      s3_r    <= s2_r;
      omd3_r  <= omd3_nxt;
      sec3_r  <= sec3_nxt;
    end
  end

  // Stage 4: chroma product.
  assign pc4_nxt = PRW'(span3_r) * PRW'(s3_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pc4_r  <= pc4_nxt;
      l24_r  <= l23_r;
      omd4_r <= omd3_r;
      sec4_r <= sec3_r;
    end
  end

  // Stage 5: chroma rounded.
  assign c5_nxt = mul_round(pc4_r);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c5_r   <= c5_nxt;
      l25_r  <= l24_r;
      omd5_r <= omd4_r;
      sec5_r <= sec4_r;
    end
  end

  // Stage 6: secondary component product.
  assign px6_nxt = PRW'(c5_r) * PRW'(omd5_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      px6_r  <= px6_nxt;
      c6_r   <= c5_r;
      l26_r  <= l25_r;
      sec6_r <= sec5_r;
    end
  end

  // Stage 7: place chroma and secondary by sector, add the doubled offset, clamp.
  function automatic logic [DBW-1:0] clamp_dbl(input logic signed [SCW-1:0] v);
    logic [DBW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SCW'(TWO_FX))) begin
      res = TWO_FX;
    end else begin
      res = v[DBW-1:0];
    end
    return res;
  endfunction

  always_comb begin
    fx_t                  x;
    fx_t                  rb, gb, bb;
    logic signed [SCW-1:0] m2;
    x  = mul_round(px6_r);
    rb = '0;
    gb = '0;
    bb = '0;
    case (sec6_r)
      3'd0: begin rb = c6_r; gb = x;    end
      3'd1: begin rb = x;    gb = c6_r; end
      3'd2: begin gb = c6_r; bb = x;    end
      3'd3: begin gb = x;    bb = c6_r; end
      3'd4: begin rb = x;    bb = c6_r; end
      default: begin rb = c6_r; bb = x; end
    endcase
    m2      = $signed(SCW'(l26_r)) - $signed(SCW'(c6_r));
    rd7_nxt = clamp_dbl($signed(SCW'({rb, 1'b0})) + m2);
    gd7_nxt = clamp_dbl($signed(SCW'({gb, 1'b0})) + m2);
    bd7_nxt = clamp_dbl($signed(SCW'({bb, 1'b0})) + m2);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rd7_r <= rd7_nxt;
      gd7_r <= gd7_nxt;
      bd7_r <= bd7_nxt;
    end
  end

  // Stage 8: doubled fraction to byte, times 255 and rounded.
  function automatic logic [BYW-1:0] to_byte(input logic [DBW-1:0] v);
    localparam int TW = DBW + BYW + 1;
    logic [TW-1:0] t;
    t = (TW'(v) << BYW) - TW'(v) + TW'(ONE_FX);
    return t[FB+1 +: BYW];
  endfunction

  assign red_nxt   = to_byte(rd7_r);
  assign green_nxt = to_byte(gd7_r);
  assign blue_nxt  = to_byte(bd7_r);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_chan.valid = vld_r[NSTG-1];
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;

endmodule

`default_nettype wire

[design/phr_checker.sv]
// Port-level assertions for the HSL to RGB unit, bound to its top level.
`default_nettype none

module phr_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_red,
  input wire [7:0] out_green,
  input wire [7:0] out_blue,
  input wire       cfg_ready
);

  // A held result keeps its colour until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("result changed while stalled");

  // The pipeline only refuses input when it is full and the output is held.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output backpressure");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // The floor register is always writable.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration write refused");

endmodule

bind packed_hsl_to_rgb_unit phr_checker u_phr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_red   (out_chan.red),
  .out_green (out_chan.green),
  .out_blue  (out_chan.blue),
  .cfg_ready (cfg_chan.ready)
);

`default_nettype wire
